FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OBST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define OBST_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define OBST_ASSERT(label, clk, rst, prop)
`define OBST_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: rtl/obst_pkg.sv
// ----------------------------------------------------------------------------
// obst_pkg
// Types, sizes and helpers for the optimal search tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

package obst_pkg;

   localparam int MAX_KEYS  = 16;
   localparam int SLOTS     = MAX_KEYS + 1;
   localparam int IDX_W     = $clog2(SLOTS + 1);
   localparam int TBL_DEPTH = SLOTS * SLOTS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int HIT_W     = 12;
   localparam int KEY_W     = 32;
   localparam int COST_W    = 22;
   localparam int WEIGHT_W  = 18;
   localparam int DEPTH_W   = 4;

   localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [TBL_AW-1:0] tbl_addr_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] prefix;  // sum of hit+miss over entries 1..k
      logic [HIT_W-1:0]    miss;
      logic [KEY_W-1:0]    key;
   } entry_word_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      idx_type           root;
   } tbl_word_type;

   typedef struct packed {
      logic           en;
      idx_type        addr;
      entry_word_type data;
   } entry_wr_type;

   typedef struct packed {
      logic         en;
      tbl_addr_type addr;
      tbl_word_type data;
   } tbl_wr_type;

   typedef struct packed {
      idx_type            lo;
      idx_type            hi;
      logic [DEPTH_W-1:0] depth;
   } span_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_WRITE,
      ST_POP,
      ST_ROOT,
      ST_KEY,
      ST_EMIT
   } state_type;

   function automatic tbl_addr_type tbl_addr(idx_type row, idx_type col);
      return TBL_AW'(row) * TBL_AW'(SLOTS) + TBL_AW'(col);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/obst_entry_mem.sv
// ----------------------------------------------------------------------------
// obst_entry_mem
// Per-entry store: prefix weight, miss weight and key. One write, two reads.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_entry_mem
   import obst_pkg::*;
(
   input  wire logic           clock,
   input  wire entry_wr_type   wr,
   input  wire idx_type        rd_a_addr,
   input  wire idx_type        rd_b_addr,
   output entry_word_type      rd_a_data,
   output entry_word_type      rd_b_data
);

   entry_word_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/obst_table_mem.sv
// ----------------------------------------------------------------------------
// obst_table_mem
// Interval cost and root table, row-major by (i, j). One write, two reads.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_table_mem
   import obst_pkg::*;
(
   input  wire logic         clock,
   input  wire tbl_wr_type   wr,
   input  wire tbl_addr_type rd_a_addr,
   input  wire tbl_addr_type rd_b_addr,
   output tbl_word_type      rd_a_data,
   output tbl_word_type      rd_b_data
);

   tbl_word_type mem [TBL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/optimal_bst_builder.sv
// ----------------------------------------------------------------------------
// optimal_bst_builder
// Optimal binary search tree: load, table fill, preorder emission.
// ----------------------------------------------------------------------------
// Entries are taken one per cycle until the one flagged last_entry. The block
// then fills the cost/root table, one interval at a time in order of length;
// for each interval the two-read table memory delivers one candidate split
// per cycle in ISSUE, then DRAIN and WRITE store the best split and its cost.
// The tree is then walked from a stack, each node passing through POP, ROOT,
// KEY and EMIT, where it waits out any output stall. No new entry is taken
// from the last entry until the final node has been accepted.
`default_nettype none
`include "assert_macros.svh"

module optimal_bst_builder
   import obst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [HIT_W-1:0]    req_hit_weight,
   input  wire logic [HIT_W-1:0]    req_miss_weight,
   input  wire logic signed [KEY_W-1:0] req_key_value,
   input  wire logic                req_last_entry,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [KEY_W-1:0]  rsp_node_key,
   output logic [4:0]               rsp_node_index,
   output logic [4:0]               rsp_range_low,
   output logic [4:0]               rsp_range_high,
   output logic [DEPTH_W-1:0]       rsp_node_depth,
   output logic [COST_W-1:0]        rsp_total_cost,
   output logic [WEIGHT_W-1:0]      rsp_total_weight,
   output logic                     rsp_empty_tree,
   output logic                     rsp_last_node
);

   state_type state_ff, state_in;
   idx_type count_ff, count_in, m_ff, m_in, len_ff, len_in, i_ff, i_in, k_ff, k_in;
   idx_type pk_ff, pk_in, bestk_ff, bestk_in, root_ff, root_in, sp_ff, sp_in;
   idx_type nodes_ff, nodes_in;
   logic [WEIGHT_W-1:0] prefix_ff, prefix_in, tw_ff, tw_in;
   logic pvalid_ff, pvalid_in, pfirst_ff, pfirst_in, pdiag_b_ff, pdiag_b_in;
   logic last_ff, last_in;
   logic [COST_W:0] best_ff, best_in;
   logic [COST_W-1:0] tc_ff, tc_in;
   span_type span_ff, span_in;
   span_type stack_ff [SLOTS];
   span_type stack_in [SLOTS];

   logic rsp_valid_ff, rsp_valid_in, rsp_empty_ff, rsp_empty_in, rsp_last_ff, rsp_last_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   idx_type rsp_idx_ff, rsp_idx_in, rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;

   entry_wr_type   ent_wr;
   idx_type        ent_rd_a_addr, ent_rd_b_addr;
   entry_word_type ent_rd_a, ent_rd_b;
   tbl_wr_type     tbl_wr;
   tbl_addr_type   tbl_rd_a_addr, tbl_rd_b_addr;
   tbl_word_type   tbl_rd_a, tbl_rd_b;

   idx_type j_idx;
   logic [COST_W-1:0] ca, cb;
   logic [COST_W:0] cand;
   logic [WEIGHT_W-1:0] w_cur;
   logic [COST_W+1:0] c_sum;
   logic [COST_W-1:0] c_sat;
   span_type top;
   logic [DEPTH_W-1:0] d_next;
   idx_type s;
   idx_type kr;

   obst_entry_mem u_entry (
      .clock     (clock),
      .wr        (ent_wr),
      .rd_a_addr (ent_rd_a_addr),
      .rd_b_addr (ent_rd_b_addr),
      .rd_a_data (ent_rd_a),
      .rd_b_data (ent_rd_b)
   );

   obst_table_mem u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .rd_a_addr (tbl_rd_a_addr),
      .rd_b_addr (tbl_rd_b_addr),
      .rd_a_data (tbl_rd_a),
      .rd_b_data (tbl_rd_b)
   );

   assign j_idx = i_ff + len_ff;
   assign top   = stack_ff[sp_ff - 1'b1];
   assign kr    = tbl_rd_a.root;

   // candidate split: diagonal intervals cost nothing and are never stored
   assign ca    = pfirst_ff  ? '0 : tbl_rd_a.cost;
   assign cb    = pdiag_b_ff ? '0 : tbl_rd_b.cost;
   assign cand  = {1'b0, ca} + {1'b0, cb};
   // w(i,j) = miss(i) + prefix(j) - prefix(i); never reaches the 18-bit limit
   assign w_cur = WEIGHT_W'(ent_rd_a.miss) + ent_rd_b.prefix - ent_rd_a.prefix;
   assign c_sum = {1'b0, best_ff} + (COST_W+2)'(w_cur);
   assign c_sat = (c_sum > (COST_W+2)'(COST_MAX)) ? COST_MAX : c_sum[COST_W-1:0];
   assign d_next = (span_ff.depth < DEPTH_MAX) ? span_ff.depth + 1'b1 : DEPTH_MAX;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      m_in          = m_ff;
      len_in        = len_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      pk_in         = k_ff;
      pfirst_in     = (k_ff == i_ff + 1'b1);
      pdiag_b_in    = (k_ff == j_idx);
      pvalid_in     = 1'b0;
      bestk_in      = bestk_ff;
      best_in       = best_ff;
      root_in       = root_ff;
      sp_in         = sp_ff;
      nodes_in      = nodes_ff;
      prefix_in     = prefix_ff;
      tw_in         = tw_ff;
      tc_in         = tc_ff;
      last_in       = last_ff;
      span_in       = span_ff;
      stack_in      = stack_ff;
      s             = sp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      ent_wr        = '0;
      tbl_wr        = '0;
      ent_rd_a_addr = i_ff;
      ent_rd_b_addr = j_idx;
      tbl_rd_a_addr = tbl_addr(i_ff, k_ff - 1'b1);
      tbl_rd_b_addr = tbl_addr(k_ff, j_idx);

      // running minimum over split points, fed by the registered read data
      if (pvalid_ff && (pfirst_ff || cand < best_ff)) begin
         best_in  = cand;
         bestk_in = pk_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < IDX_W'(SLOTS)) begin
                  ent_wr.en          = 1'b1;
                  ent_wr.addr        = count_ff;
                  ent_wr.data.miss   = req_miss_weight;
                  ent_wr.data.key    = req_key_value;
                  ent_wr.data.prefix = (count_ff == '0) ? '0 :
                     prefix_ff + WEIGHT_W'(req_hit_weight) + WEIGHT_W'(req_miss_weight);
                  prefix_in = ent_wr.data.prefix;
                  count_in  = count_ff + 1'b1;
               end
               if (req_last_entry) begin
                  count_in = '0;
                  m_in = (count_ff < IDX_W'(SLOTS)) ? count_ff : IDX_W'(MAX_KEYS);
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_key_in    = '0;
                     rsp_idx_in    = '0;
                     rsp_lo_in     = '0;
                     rsp_hi_in     = '0;
                     rsp_depth_in  = '0;
                     rsp_cost_in   = '0;
                     rsp_weight_in = WEIGHT_W'(req_miss_weight);
                     rsp_empty_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_EMIT;
                  end else begin
                     len_in   = IDX_W'(1);
                     i_in     = '0;
                     k_in     = IDX_W'(1);
                     state_in = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            pvalid_in = 1'b1;
            if (k_ff == j_idx) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            tbl_wr.en        = 1'b1;
            tbl_wr.addr      = tbl_addr(i_ff, j_idx);
            tbl_wr.data.cost = c_sat;
            tbl_wr.data.root = bestk_ff;
            tc_in            = c_sat;
            tw_in            = w_cur;
            state_in         = ST_ISSUE;
            if (j_idx == m_ff) begin
               if (len_ff == m_ff) begin
                  stack_in[0] = '{lo: '0, hi: m_ff, depth: '0};
                  sp_in       = IDX_W'(1);
                  nodes_in    = '0;
                  state_in    = ST_POP;
               end else begin
                  len_in = len_ff + 1'b1;
                  i_in   = '0;
                  k_in   = IDX_W'(1);
               end
            end else begin
               i_in = i_ff + 1'b1;
               k_in = i_ff + 2'd2;
            end
         end
         ST_POP: begin
            tbl_rd_a_addr = tbl_addr(top.lo, top.hi);
            span_in       = top;
            sp_in         = sp_ff - 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            ent_rd_a_addr = kr;
            root_in       = kr;
            if (kr < span_ff.hi && s < IDX_W'(SLOTS)) begin
               stack_in[s] = '{lo: kr, hi: span_ff.hi, depth: d_next};
               s = s + 1'b1;
            end
            if (kr - 1'b1 > span_ff.lo && s < IDX_W'(SLOTS)) begin
               stack_in[s] = '{lo: span_ff.lo, hi: kr - 1'b1, depth: d_next};
               s = s + 1'b1;
            end
            sp_in    = s;
            nodes_in = nodes_ff + 1'b1;
            last_in  = (s == '0) || (nodes_ff + 1'b1 == IDX_W'(MAX_KEYS));
            state_in = ST_KEY;
         end
         ST_KEY: begin
            rsp_valid_in  = 1'b1;
            rsp_key_in    = ent_rd_a.key;
            rsp_idx_in    = root_ff;
            rsp_lo_in     = span_ff.lo;
            rsp_hi_in     = span_ff.hi;
            rsp_depth_in  = span_ff.depth;
            rsp_cost_in   = tc_ff;
            rsp_weight_in = tw_ff + WEIGHT_W'(0);
            rsp_empty_in  = 1'b0;
            rsp_last_in   = last_ff;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? ST_LOAD : ST_POP;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sp_ff        <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      len_ff        <= len_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      pk_ff         <= pk_in;
      pfirst_ff     <= pfirst_in;
      pdiag_b_ff    <= pdiag_b_in;
      bestk_ff      <= bestk_in;
      best_ff       <= best_in;
      root_ff       <= root_in;
      nodes_ff      <= nodes_in;
      prefix_ff     <= prefix_in;
      tw_ff         <= tw_in;
      tc_ff         <= tc_in;
      last_ff       <= last_in;
      span_ff       <= span_in;
      stack_ff      <= stack_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_key     = rsp_key_ff;
   assign rsp_node_index   = rsp_idx_ff;
   assign rsp_range_low    = rsp_lo_ff;
   assign rsp_range_high   = rsp_hi_ff;
   assign rsp_node_depth   = rsp_depth_ff;
   assign rsp_total_cost   = rsp_cost_ff;
   assign rsp_total_weight = rsp_weight_ff;
   assign rsp_empty_tree   = rsp_empty_ff;
   assign rsp_last_node    = rsp_last_ff;

   `OBST_NEVER(a_ready_while_busy, clock, reset, req_ready && rsp_valid)
   `OBST_ASSERT(a_stack_bound, clock, reset, sp_ff <= IDX_W'(SLOTS))
   `OBST_ASSERT(a_root_in_span, clock, reset, (state_ff == ST_ROOT) |-> (kr > span_ff.lo && kr <= span_ff.hi))
   `OBST_ASSERT(a_split_in_span, clock, reset, (state_ff == ST_WRITE) |-> (bestk_ff > i_ff && bestk_ff <= j_idx))

endmodule

`default_nettype wire
